// ===== sv/pil_pkg.sv =====
// ----------------------------------------------------------------------------
// pil_pkg
// shared types, widths and codes of the positional insert list unit
// ----------------------------------------------------------------------------
package pil_pkg;

  localparam int CAPACITY = 32;

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int ST_W  = 2;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = POS_W + 1;

  localparam logic [OP_W-1:0] OP_HEAD = 2'd0;
  localparam logic [OP_W-1:0] OP_POS  = 2'd1;
  localparam logic [OP_W-1:0] OP_TAIL = 2'd2;
  localparam logic [OP_W-1:0] OP_READ = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  localparam logic [1:0] FIFO_FULL = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] element;
    logic [ST_W-1:0]         status;
    logic                    last;
  } pil_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       pop;
  } pil_fifo_st_t;

endpackage

// ===== sv/pil_if.sv =====
// ----------------------------------------------------------------------------
// pil_in_if / pil_out_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface pil_in_if;
  logic                             valid;
  logic                             ready;
  logic [pil_pkg::OP_W-1:0]         opcode;
  logic signed [pil_pkg::VAL_W-1:0] value;
  logic [pil_pkg::POS_W-1:0]        position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface pil_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pil_pkg::VAL_W-1:0] element;
  logic [pil_pkg::ST_W-1:0]         status;
  logic                             last;

  modport source (output valid, output element, output status, output last, input ready);
  modport sink   (input valid, input element, input status, input last, output ready);
endinterface

// ===== sv/positional_insert_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_insert_list_unit
// ordered list of signed 32-bit values with head, position and tail insert
// ----------------------------------------------------------------------------
// Commands enter on in_i (opcode, value, position) and results leave on out_o
// (element, status, last), both valid/ready; a transfer happens when both are
// high. Every insert gives one status result; a readout gives one result per
// element with last on the final one, or one empty-status result.
// The list lives in a single simple dual port RAM (one write, one registered
// read per cycle). An insert at slot idx moves count-idx entries one place
// toward the tail at one entry per cycle, then writes the new value and posts
// its status; an insert at the tail moves no entries, and a refused command
// posts its status without touching the list.
// A readout streams one element per cycle through the RAM read port while
// the output queue has room.
// One command is processed at a time; the next command is taken once the
// previous one has posted all its results to the two-entry output queue.
// When out_o stalls, the queue fills and the sequencer waits; nothing is lost.
// Reset empties the list and the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module positional_insert_list_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  pil_in_if.sink        in_i,
  pil_out_if.source     out_o
);
  import pil_pkg::*;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  pil_fifo_st_t     fst;
  logic             push;
  pil_res_t         push_res;
  pil_res_t         out_res;

  pil_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_opcode_i   (in_i.opcode),
    .in_value_i    (in_i.value),
    .in_position_i (in_i.position),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .fst_i         (fst),
    .push_o        (push),
    .res_o         (push_res)
  );

  pil_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pil_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (push_res),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_res),
    .st_o    (fst)
  );

  assign out_o.element = out_res.element;
  assign out_o.status  = out_res.status;
  assign out_o.last    = out_res.last;

endmodule

// ===== sv/pil_ram.sv =====
// ----------------------------------------------------------------------------
// pil_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pil_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/pil_ofifo.sv =====
// ----------------------------------------------------------------------------
// pil_ofifo
// two-entry result queue between the sequencer and the result channel
// ----------------------------------------------------------------------------
module pil_ofifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pil_pkg::pil_res_t     res_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output pil_pkg::pil_res_t     res_o,
  output pil_pkg::pil_fifo_st_t st_o
);
  import pil_pkg::*;

  pil_res_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o & ready_i;
  assign res_o   = slot_q[rd_ptr_q];
  assign st_o    = '{cnt: cnt_q, pop: pop};

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== sv/pil_ctrl.sv =====
// ----------------------------------------------------------------------------
// pil_ctrl
// command sequencer: shifts entries in memory, inserts, reads out the list
// ----------------------------------------------------------------------------
module pil_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pil_pkg::OP_W-1:0]         in_opcode_i,
  input  logic signed [pil_pkg::VAL_W-1:0] in_value_i,
  input  logic [pil_pkg::POS_W-1:0]        in_position_i,
  output logic                             ram_we_o,
  output logic [pil_pkg::IDX_W-1:0]        ram_waddr_o,
  output logic [pil_pkg::VAL_W-1:0]        ram_wdata_o,
  output logic [pil_pkg::IDX_W-1:0]        ram_raddr_o,
  input  logic [pil_pkg::VAL_W-1:0]        ram_rdata_i,
  input  pil_pkg::pil_fifo_st_t            fst_i,
  output logic                             push_o,
  output pil_pkg::pil_res_t                res_o
);
  import pil_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_STAT  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [ST_W-1:0]  stat_q, stat_d;
  logic             wr_pend_q, wr_pend_d;
  logic [IDX_W-1:0] wr_addr_q, wr_addr_d;
  logic             rd_out_q, rd_out_d;
  logic             rd_last_q, rd_last_d;

  logic             accept;
  logic             list_full;
  logic             pos_bad;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [POS_W-1:0] pos_m1;
  logic [IDX_W-1:0] idx_new;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] shift_raddr;
  logic [2:0]       occ;
  logic             credit_ok;
  logic             fifo_full;
  logic             read_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  assign list_full = (count_q == CNT_W'(CAPACITY));
  assign cnt_ext   = CMP_W'(count_q);
  assign pos_ext   = CMP_W'(in_position_i);
  assign pos_bad   = (in_position_i == '0) || (pos_ext > cnt_ext + CMP_W'(1));
  assign pos_m1    = in_position_i - POS_W'(1);
  assign tail_idx  = count_q[IDX_W-1:0];

  always_comb begin
    case (in_opcode_i)
      OP_HEAD: idx_new = '0;
      OP_POS:  idx_new = pos_m1[IDX_W-1:0];
      default: idx_new = tail_idx;
    endcase
  end

  assign shift_raddr = ptr_q - IDX_W'(1);
  assign occ         = 3'(fst_i.cnt) + 3'(rd_out_q) - 3'(fst_i.pop);
  assign credit_ok   = (occ < 3'd2);
  assign fifo_full   = (fst_i.cnt == FIFO_FULL);
  assign read_last   = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    val_d     = val_q;
    stat_d    = stat_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    rd_out_d  = 1'b0;
    rd_last_d = rd_last_q;

    ram_we_o    = wr_pend_q;
    ram_waddr_o = wr_addr_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = ptr_q;

    push_o = 1'b0;
    res_o  = '0;

    // read data landing from the readout loop
    if (rd_out_q) begin
      push_o         = 1'b1;
      res_o.element  = ram_rdata_i;
      res_o.status   = ST_OK;
      res_o.last     = rd_last_q;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d = in_value_i;
          if (in_opcode_i == OP_READ) begin
            if (count_q == '0) begin
              stat_d  = ST_EMPTY;
              state_d = S_STAT;
            end else begin
              ptr_d   = '0;
              state_d = S_READ;
            end
          end else if (list_full) begin
            stat_d  = ST_FULL;
            state_d = S_STAT;
          end else if ((in_opcode_i == OP_POS) && pos_bad) begin
            stat_d  = ST_RANGE;
            state_d = S_STAT;
          end else begin
            idx_d  = idx_new;
            stat_d = ST_OK;
            if (idx_new == tail_idx) begin
              state_d = S_PUT;
            end else begin
              ptr_d   = tail_idx;
              state_d = S_SHIFT;
            end
          end
        end
      end
      S_SHIFT: begin
        // read slot ptr-1 now, write it to slot ptr next cycle
        ram_raddr_o = shift_raddr;
        wr_pend_d   = 1'b1;
        wr_addr_d   = ptr_q;
        ptr_d       = shift_raddr;
        if (shift_raddr == idx_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_PUT;
      end
      S_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q;
        ram_wdata_o = val_q;
        count_d     = count_q + CNT_W'(1);
        state_d     = S_STAT;
      end
      S_STAT: begin
        if (!fifo_full) begin
          push_o       = 1'b1;
          res_o.status = stat_q;
          res_o.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_READ: begin
        if (credit_ok) begin
          rd_out_d  = 1'b1;
          rd_last_d = read_last;
          ptr_d     = ptr_q + IDX_W'(1);
          if (read_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      wr_pend_q <= 1'b0;
      rd_out_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      wr_pend_q <= wr_pend_d;
      rd_out_q  <= rd_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
    stat_q    <= stat_d;
    wr_addr_q <= wr_addr_d;
    rd_last_q <= rd_last_d;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (!fifo_full || fst_i.pop))
    else $error("result pushed into full queue");

  a_put_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_drain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (wr_pend_q && ram_we_o))
    else $error("shift drain without pending write");
`endif

endmodule
